>>> design/cpu8_alu_with_bcd_core_assert.svh
// assertion macros for the checker file of the alu core
`ifndef CPU8_ALU_WITH_BCD_CORE_ASSERT_SVH
`define CPU8_ALU_WITH_BCD_CORE_ASSERT_SVH

// clocked assertion that is switched off while reset is held
`define C8ALU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define C8ALU_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/c8alu_pkg.sv
// types and operation codes of the 8-bit alu core
package c8alu_pkg;

    // operation codes, codes 13 to 15 pass the register byte through
    typedef enum logic [3:0] {
        ALU_ADD  = 4'd0,
        ALU_SUB  = 4'd1,
        ALU_AND  = 4'd2,
        ALU_OR   = 4'd3,
        ALU_XOR  = 4'd4,
        ALU_CMP  = 4'd5,
        ALU_SHL  = 4'd6,
        ALU_SHR  = 4'd7,
        ALU_ROTL = 4'd8,
        ALU_ROTR = 4'd9,
        ALU_INC  = 4'd10,
        ALU_DEC  = 4'd11,
        ALU_BIT  = 4'd12
    } t_alu_op;

    // bcd adjust constants
    localparam logic [4:0] BCD_LO_LIMIT = 5'h0A;
    localparam logic [3:0] BCD_LO_ADJ   = 4'h6;
    localparam logic [9:0] BCD_HI_LIMIT = 10'h0A0;
    localparam logic [9:0] BCD_HI_ADJ   = 10'h060;

    // one operation request
    typedef struct packed {
        logic [3:0] req_type;
        logic [7:0] reg_value;
        logic [7:0] operand;
        logic       carry_in;
        logic       overflow_in;
        logic       decimal_in;
    } t_c8alu_req;

    // one operation result
    typedef struct packed {
        logic [7:0] result;
        logic       carry_out;
        logic       zero_out;
        logic       negative_out;
        logic       overflow_out;
    } t_c8alu_rsp;

endpackage

>>> design/c8alu_ifs.sv
// valid/ready channel interfaces for alu requests and results
interface c8alu_req_if;
    logic       valid;
    logic       ready;
    logic [3:0] req_type;
    logic [7:0] reg_value;
    logic [7:0] operand;
    logic       carry_in;
    logic       overflow_in;
    logic       decimal_in;

    modport source (output valid, req_type, reg_value, operand, carry_in, overflow_in,
                    decimal_in, input ready);
    modport sink   (input valid, req_type, reg_value, operand, carry_in, overflow_in,
                    decimal_in, output ready);
endinterface

interface c8alu_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] result;
    logic       carry_out;
    logic       zero_out;
    logic       negative_out;
    logic       overflow_out;

    modport source (output valid, result, carry_out, zero_out, negative_out, overflow_out,
                    input ready);
    modport sink   (input valid, result, carry_out, zero_out, negative_out, overflow_out,
                    output ready);
endinterface

>>> design/c8alu_exec.sv
// combinational execute logic: binary and bcd add/sub, logic, shifts, flags
module c8alu_exec
    import c8alu_pkg::*;
(
    input  t_c8alu_req i_req,
    output t_c8alu_rsp o_rsp
);

    logic [7:0]         a;
    logic [7:0]         m;
    logic               c;
    logic [4:0]         add_lo;
    logic [9:0]         add_s;
    logic signed [5:0]  sub_lo;
    logic [3:0]         sub_lo_adj;
    logic signed [10:0] sub_s;
    logic [8:0]         cmp_d;
    logic [7:0]         r;
    logic               c_new;
    logic               v_new;
    logic               z_new;
    logic               n_new;

    assign a = i_req.reg_value;
    assign m = i_req.operand;
    assign c = i_req.carry_in;

    // adder, decimal path adjusts each nibble
    always_comb begin
        add_lo = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'b0, c};
        add_s  = '0;
        if (i_req.decimal_in) begin
            if (add_lo >= BCD_LO_LIMIT) begin
                add_lo = {1'b0, add_lo[3:0] + BCD_LO_ADJ} + 5'h10;
            end
            add_s = {2'b0, a[7:4], 4'b0} + {2'b0, m[7:4], 4'b0} + {5'b0, add_lo};
            if (add_s >= BCD_HI_LIMIT) begin
                add_s = add_s + BCD_HI_ADJ;
            end
        end else begin
            add_s = {2'b0, a} + {2'b0, m} + {9'b0, c};
        end
    end

    // subtractor, borrow is the inverted carry
    always_comb begin
        sub_lo     = $signed({2'b0, a[3:0]}) - $signed({2'b0, m[3:0]})
                     - $signed({5'b0, ~c});
        sub_lo_adj = sub_lo[3:0] - BCD_LO_ADJ;
        sub_s      = '0;
        if (i_req.decimal_in) begin
            if (sub_lo[5]) begin
                sub_lo = $signed({2'b0, sub_lo_adj}) - 6'sd16;
            end
            sub_s = $signed({3'b0, a[7:4], 4'b0}) - $signed({3'b0, m[7:4], 4'b0})
                    + $signed({{5{sub_lo[5]}}, sub_lo});
            if (sub_s[10]) begin
                sub_s = sub_s - 11'sd96;
            end
        end else begin
            sub_s = $signed({3'b0, a}) - $signed({3'b0, m}) - $signed({10'b0, ~c});
        end
    end

    assign cmp_d = {1'b0, a} - {1'b0, m};

    // result and flag select
    always_comb begin
        r     = a;
        c_new = c;
        v_new = i_req.overflow_in;
        case (i_req.req_type)
            ALU_ADD: begin
                r     = add_s[7:0];
                c_new = add_s[9] | add_s[8];
                v_new = (a[7] ^ r[7]) & (m[7] ^ r[7]);
            end
            ALU_SUB: begin
                r     = sub_s[7:0];
                c_new = ~sub_s[10];
                v_new = (a[7] ^ r[7]) & (~m[7] ^ r[7]);
            end
            ALU_AND: r = a & m;
            ALU_OR:  r = a | m;
            ALU_XOR: r = a ^ m;
            ALU_CMP: begin
                r     = cmp_d[7:0];
                c_new = ~cmp_d[8];
            end
            ALU_SHL: begin
                r     = {m[6:0], 1'b0};
                c_new = m[7];
            end
            ALU_SHR: begin
                r     = {1'b0, m[7:1]};
                c_new = m[0];
            end
            ALU_ROTL: begin
                r     = {m[6:0], c};
                c_new = m[7];
            end
            ALU_ROTR: begin
                r     = {c, m[7:1]};
                c_new = m[0];
            end
            ALU_INC: r = m + 8'd1;
            ALU_DEC: r = m - 8'd1;
            ALU_BIT: r = a;
            default: r = a;
        endcase
        // bit test takes zero from the masked value and sign and overflow from the operand
        if (i_req.req_type == ALU_BIT) begin
            z_new = ((a & m) == 8'h00);
            n_new = m[7];
            v_new = m[6];
        end else begin
            z_new = (r == 8'h00);
            n_new = r[7];
        end
    end

    assign o_rsp = '{result: r, carry_out: c_new, zero_out: z_new,
                     negative_out: n_new, overflow_out: v_new};

endmodule

>>> design/cpu8_alu_with_bcd_core.sv
// Top level of the 8-bit alu core with bcd add/subtract. Requests pass through an
// input register, one pass of execute logic and a result register, which takes the
// executed request whenever it is free; one request is taken every cycle as long as
// results are taken; a stalled result register holds its request while the input
// register still takes one more, and ready returns the cycle the result is taken.
// The core keeps no state beyond these two registers.
module cpu8_alu_with_bcd_core
    import c8alu_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    c8alu_req_if.sink     i_req,
    c8alu_rsp_if.source   o_rsp
);

    t_c8alu_req r_req;
    logic       r_req_vld;
    logic       n_req_vld;
    t_c8alu_rsp r_rsp;
    logic       r_rsp_vld;
    logic       n_rsp_vld;
    t_c8alu_rsp exec_rsp;
    logic       rsp_free;
    logic       req_free;
    logic       req_take;

    // stage handshake
    assign rsp_free    = ~r_rsp_vld | o_rsp.ready;
    assign req_free    = ~r_req_vld | rsp_free;
    assign req_take    = i_req.valid & req_free;
    assign i_req.ready = req_free;

    always_comb begin
        n_req_vld = r_req_vld;
        if (req_free) begin
            n_req_vld = i_req.valid;
        end
        n_rsp_vld = r_rsp_vld;
        if (rsp_free) begin
            n_rsp_vld = r_req_vld;
        end
    end

    // valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            r_req_vld <= n_req_vld;
            r_rsp_vld <= n_rsp_vld;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_req <= '{req_type: i_req.req_type, reg_value: i_req.reg_value,
                       operand: i_req.operand, carry_in: i_req.carry_in,
                       overflow_in: i_req.overflow_in, decimal_in: i_req.decimal_in};
        end
    end

    c8alu_exec u_exec (
        .i_req (r_req),
        .o_rsp (exec_rsp)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (rsp_free && r_req_vld) begin
            r_rsp <= exec_rsp;
        end
    end

    assign o_rsp.valid        = r_rsp_vld;
    assign o_rsp.result       = r_rsp.result;
    assign o_rsp.carry_out    = r_rsp.carry_out;
    assign o_rsp.zero_out     = r_rsp.zero_out;
    assign o_rsp.negative_out = r_rsp.negative_out;
    assign o_rsp.overflow_out = r_rsp.overflow_out;

endmodule

>>> design/c8alu_chk.sv
// port checker for the alu core and its bind
`include "cpu8_alu_with_bcd_core_assert.svh"

module c8alu_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_result,
    input logic [3:0] i_out_flags
);

    // stalled result holds
    `C8ALU_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_result) && $stable(i_out_flags), "stalled result changed")

    // no result leaves reset
    `C8ALU_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // a taken result sink never blocks new requests
    `C8ALU_ASSERT(a_ready_pass, i_clk, i_rst_n, i_out_ready |-> i_in_ready, "request blocked while results drain")

    // a taken request reaches the output when the sink is ready while it sits in the input register
    `C8ALU_ASSERT(a_latency, i_clk, i_rst_n, i_in_valid && i_in_ready ##1 i_out_ready |=> i_out_valid, "request lost in pipeline")

endmodule

bind cpu8_alu_with_bcd_core c8alu_chk u_c8alu_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_result (o_rsp.result),
    .i_out_flags  ({o_rsp.carry_out, o_rsp.zero_out, o_rsp.negative_out,
                    o_rsp.overflow_out})
);

>>> bench/testbench.sv
// testbench for the 8-bit alu core with bcd add/subtract
`timescale 1ns / 100ps

module testbench;
    import c8alu_pkg::*;

    localparam int         RANDOM_REQS    = 450;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 8;
    localparam int         MAX_REPORTS    = 100;
    // receiver holds off once for a long stretch after this many results
    localparam int         HOLD_AT_RSP    = 150;
    localparam int         HOLD_CYCLES    = 60;
    // windows with no idling on each side
    localparam int         REQ_BURST_LO   = 100;
    localparam int         REQ_BURST_HI   = 180;
    localparam int         RSP_BURST_LO   = 250;
    localparam int         RSP_BURST_HI   = 330;
    // codes above the last operation pass the register byte through
    localparam logic [3:0] OP_SPARE_FIRST = 4'd13;
    localparam logic [3:0] OP_SPARE_LAST  = 4'd15;

    logic i_clk;
    logic i_rst_n;

    c8alu_req_if req_ch();
    c8alu_rsp_if rsp_ch();

    cpu8_alu_with_bcd_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_c8alu_req pending_reqs[$];
    t_c8alu_rsp expected_rsps[$];
    int         n_errors     = 0;
    int         n_reqs_taken = 0;
    int         n_rsps_taken = 0;
    int         req_gap;
    int         rsp_stall;
    int         rsp_hold;
    int         idle_cycles  = 0;

    // expected flags and byte of one alu operation
    function automatic t_c8alu_rsp alu_predict(t_c8alu_req rq);
        logic [7:0] a;
        logic [7:0] m;
        logic [7:0] r;
        logic       c;
        logic       v;
        logic       z;
        logic       n;
        int         lo;
        int         s;
        t_c8alu_rsp rs;
        a = rq.reg_value;
        m = rq.operand;
        c = rq.carry_in;
        v = rq.overflow_in;
        r = a;
        case (t_alu_op'(rq.req_type))
            ALU_ADD: begin
                if (rq.decimal_in) begin
                    // low digit carries into the high digit once it passes nine
                    lo = int'(a[3:0]) + int'(m[3:0]) + int'(c);
                    if (lo >= 10) lo = ((lo + 6) & 15) + 16;
                    s = int'(a & 8'hF0) + int'(m & 8'hF0) + lo;
                    if (s >= 160) s = s + 96;
                end else begin
                    s = int'(a) + int'(m) + int'(c);
                end
                r = s[7:0];
                v = (a[7] ^ r[7]) & (m[7] ^ r[7]);
                c = (s > 255);
            end
            ALU_SUB: begin
                if (rq.decimal_in) begin
                    // low digit borrows from the high digit when it goes negative
                    lo = int'(a[3:0]) - int'(m[3:0]) - int'(!c);
                    if (lo < 0) lo = ((lo - 6) & 15) - 16;
                    s = int'(a & 8'hF0) - int'(m & 8'hF0) + lo;
                    if (s < 0) s = s - 96;
                end else begin
                    s = int'(a) - int'(m) - int'(!c);
                end
                r = s[7:0];
                v = (a[7] ^ r[7]) & (~m[7] ^ r[7]);
                c = (s >= 0);
            end
            ALU_AND: r = a & m;
            ALU_OR:  r = a | m;
            ALU_XOR: r = a ^ m;
            ALU_CMP: begin
                r = a - m;
                c = (a >= m);
            end
            ALU_SHL: begin
                r = {m[6:0], 1'b0};
                c = m[7];
            end
            ALU_SHR: begin
                r = {1'b0, m[7:1]};
                c = m[0];
            end
            ALU_ROTL: begin
                r = {m[6:0], c};
                c = m[7];
            end
            ALU_ROTR: begin
                r = {c, m[7:1]};
                c = m[0];
            end
            ALU_INC: r = m + 8'd1;
            ALU_DEC: r = m - 8'd1;
            default: r = a;
        endcase
        z = (r == 8'h00);
        n = r[7];
        // bit test takes its flags from the masked value and the operand
        if (t_alu_op'(rq.req_type) == ALU_BIT) begin
            z = ((a & m) == 8'h00);
            n = m[7];
            v = m[6];
        end
        rs.result       = r;
        rs.carry_out    = c;
        rs.zero_out     = z;
        rs.negative_out = n;
        rs.overflow_out = v;
        return rs;
    endfunction

    task automatic queue_req(logic [3:0] op, logic [7:0] a, logic [7:0] m,
                             logic c, logic v, logic d);
        t_c8alu_req rq;
        rq.req_type    = op;
        rq.reg_value   = a;
        rq.operand     = m;
        rq.carry_in    = c;
        rq.overflow_in = v;
        rq.decimal_in  = d;
        pending_reqs.push_back(rq);
    endtask

    // byte biased toward the boundary values
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // request driver, fed from the pending queue
    always @(posedge i_clk) begin : req_driver
        t_c8alu_req taken;
        t_c8alu_req nxt;
        logic       next_valid;
        if (!i_rst_n) begin
            req_ch.valid       <= 1'b0;
            req_ch.req_type    <= '0;
            req_ch.reg_value   <= '0;
            req_ch.operand     <= '0;
            req_ch.carry_in    <= 1'b0;
            req_ch.overflow_in <= 1'b0;
            req_ch.decimal_in  <= 1'b0;
            req_gap = 0;
        end else begin
            next_valid = req_ch.valid;
            if (req_ch.valid && req_ch.ready) begin
                taken.req_type    = req_ch.req_type;
                taken.reg_value   = req_ch.reg_value;
                taken.operand     = req_ch.operand;
                taken.carry_in    = req_ch.carry_in;
                taken.overflow_in = req_ch.overflow_in;
                taken.decimal_in  = req_ch.decimal_in;
                expected_rsps.push_back(alu_predict(taken));
                n_reqs_taken++;
                if (n_reqs_taken >= REQ_BURST_LO && n_reqs_taken < REQ_BURST_HI)
                    req_gap = 0;
                else
                    req_gap = $urandom_range(0, 4);
                next_valid = 1'b0;
            end
            // offer the next request once the gap has run out
            if (!next_valid) begin
                if (req_gap > 0) begin
                    req_gap--;
                end else if (pending_reqs.size() > 0) begin
                    nxt = pending_reqs.pop_front();
                    req_ch.req_type    <= nxt.req_type;
                    req_ch.reg_value   <= nxt.reg_value;
                    req_ch.operand     <= nxt.operand;
                    req_ch.carry_in    <= nxt.carry_in;
                    req_ch.overflow_in <= nxt.overflow_in;
                    req_ch.decimal_in  <= nxt.decimal_in;
                    next_valid = 1'b1;
                end
            end
            req_ch.valid <= next_valid;
        end
    end

    // result monitor with random stalls and one long hold-off
    always @(posedge i_clk) begin : rsp_monitor
        t_c8alu_rsp want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall = 0;
            rsp_hold  = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                n_rsps_taken++;
                if (expected_rsps.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: unexpected result: expected none, actual %h %b%b%b%b",
                                 $time, rsp_ch.result, rsp_ch.carry_out, rsp_ch.zero_out,
                                 rsp_ch.negative_out, rsp_ch.overflow_out);
                end else begin
                    want = expected_rsps.pop_front();
                    check_field("result", want.result, rsp_ch.result);
                    check_field("carry", 8'(want.carry_out), 8'(rsp_ch.carry_out));
                    check_field("zero", 8'(want.zero_out), 8'(rsp_ch.zero_out));
                    check_field("negative", 8'(want.negative_out), 8'(rsp_ch.negative_out));
                    check_field("overflow", 8'(want.overflow_out), 8'(rsp_ch.overflow_out));
                end
                if (n_rsps_taken >= RSP_BURST_LO && n_rsps_taken < RSP_BURST_HI)
                    rsp_stall = 0;
                else
                    rsp_stall = $urandom_range(0, 4);
                if (n_rsps_taken == HOLD_AT_RSP)
                    rsp_hold = HOLD_CYCLES;
            end
            if (rsp_hold > 0) begin
                rsp_hold--;
                rsp_ch.ready <= 1'b0;
            end else if (rsp_stall > 0) begin
                rsp_stall--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no request or result taken
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus, reset and end of run
    initial begin : stimulus
        logic [3:0] op;
        logic [7:0] a;
        logic [7:0] m;
        logic       d;
        i_rst_n = 1'b0;

        // binary add: zero, carry out, overflow with carry in, overflow and carry
        queue_req(ALU_ADD, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
        queue_req(ALU_ADD, 8'hFF, 8'h01, 1'b0, 1'b0, 1'b0);
        queue_req(ALU_ADD, 8'h7F, 8'h00, 1'b1, 1'b0, 1'b0);
        queue_req(ALU_ADD, 8'h80, 8'h80, 1'b0, 1'b0, 1'b0);
        // decimal add: wrap to zero, both digits adjusted, digits above nine
        queue_req(ALU_ADD, 8'h99, 8'h01, 1'b0, 1'b0, 1'b1);
        queue_req(ALU_ADD, 8'h58, 8'h46, 1'b1, 1'b0, 1'b1);
        queue_req(ALU_ADD, 8'h0F, 8'h0F, 1'b0, 1'b0, 1'b1);
        // binary subtract: borrow, signed overflow, equal with borrow in
        queue_req(ALU_SUB, 8'h00, 8'h01, 1'b1, 1'b0, 1'b0);
        queue_req(ALU_SUB, 8'h80, 8'h01, 1'b1, 1'b0, 1'b0);
        queue_req(ALU_SUB, 8'h50, 8'h50, 1'b0, 1'b0, 1'b0);
        // decimal subtract: borrow through both digits, plain, digits above nine
        queue_req(ALU_SUB, 8'h00, 8'h01, 1'b1, 1'b0, 1'b1);
        queue_req(ALU_SUB, 8'h46, 8'h12, 1'b0, 1'b0, 1'b1);
        queue_req(ALU_SUB, 8'h0A, 8'hFF, 1'b1, 1'b1, 1'b1);
        // logic ops keep carry and overflow
        queue_req(ALU_AND, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b0);
        queue_req(ALU_OR,  8'h80, 8'h01, 1'b0, 1'b1, 1'b0);
        queue_req(ALU_XOR, 8'hAA, 8'hAA, 1'b1, 1'b0, 1'b0);
        // compare equal and below
        queue_req(ALU_CMP, 8'h40, 8'h40, 1'b0, 1'b1, 1'b0);
        queue_req(ALU_CMP, 8'h10, 8'h20, 1'b1, 1'b0, 1'b0);
        // shifts and rotates with the bit shifted out
        queue_req(ALU_SHL,  8'h00, 8'h80, 1'b0, 1'b0, 1'b0);
        queue_req(ALU_SHR,  8'h00, 8'h01, 1'b0, 1'b1, 1'b0);
        queue_req(ALU_ROTL, 8'h00, 8'h80, 1'b1, 1'b0, 1'b0);
        queue_req(ALU_ROTR, 8'h00, 8'h01, 1'b1, 1'b1, 1'b0);
        // increment and decrement wrap
        queue_req(ALU_INC, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0);
        queue_req(ALU_DEC, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);
        // bit test with nothing in common
        queue_req(ALU_BIT, 8'h3F, 8'hC0, 1'b1, 1'b0, 1'b0);
        // unused codes pass the register byte
        queue_req(OP_SPARE_FIRST, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1);
        queue_req(OP_SPARE_LAST,  8'h80, 8'h00, 1'b0, 1'b0, 1'b0);

        // random requests, decimal ones often with valid digits
        repeat (RANDOM_REQS) begin
            if ($urandom_range(0, 9) == 0)
                op = 4'($urandom_range(int'(OP_SPARE_FIRST), int'(OP_SPARE_LAST)));
            else
                op = 4'($urandom_range(int'(ALU_ADD), int'(ALU_BIT)));
            d = 1'($urandom_range(0, 1));
            a = pick_byte();
            m = pick_byte();
            if (d && (op == ALU_ADD || op == ALU_SUB) && $urandom_range(0, 2) != 0) begin
                a = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
                m = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            end
            queue_req(op, a, m, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), d);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every request to be taken and every result to arrive
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
